[rtl/sst_pkg.sv]
// ----------------------------------------------------------------------------
// SRTP session table package
// Command and status codes, field widths and the structures shared between
// the sequencer and the top level.
// ----------------------------------------------------------------------------
package sst_pkg;

    // field widths
    localparam int SRC_W    = 32;
    localparam int CNT_W    = 32;
    localparam int POL_W    = 8;
    localparam int ID_W     = 8;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_APPEND     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_OVERWRITE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET_COUNT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET_SOURCE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOOKUP     = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

    // per-field write strobes into the session stores
    typedef struct packed {
        logic src;
        logic cnt;
        logic pol;
    } wr_en_t;

    // one result transaction
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     found_id;
        logic [CNT_W-1:0]    found_count;
        logic [POL_W-1:0]    found_policy;
    } result_t;

endpackage

[rtl/sst_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/sst_ctrl.sv]
// ----------------------------------------------------------------------------
// SRTP session table sequencer
// Decodes each command, drives the session store writes and scans the
// source store one entry per cycle through a single comparator on lookup.
// ----------------------------------------------------------------------------
module sst_ctrl
    import sst_pkg::*;
#(
    parameter int ENTRIES = 16,
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int CW = $clog2(ENTRIES + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    // command transaction
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [CMD_W-1:0] cmd,
    input  logic [SRC_W-1:0] src,
    input  logic [CNT_W-1:0] cnt,
    input  logic [POL_W-1:0] pol,
    input  logic [ID_W-1:0]  id,
    // session store ports
    output wr_en_t           wr_en,
    output logic [AW-1:0]    wr_addr,
    output logic             rd_en,
    output logic [AW-1:0]    rd_addr,
    input  logic [SRC_W-1:0] rd_src,
    input  logic [CNT_W-1:0] rd_cnt,
    input  logic [POL_W-1:0] rd_pol,
    // result hand-off
    output logic             res_valid,
    output result_t          res,
    input  logic             res_take
);

    localparam int IW = (CW > ID_W) ? CW : ID_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CW-1:0]    total_reg, total_next;
    logic [SRC_W-1:0] key_reg, key_next;
    logic [CW-1:0]    rd_idx_reg, rd_idx_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic [CW-1:0]    cmp_idx_reg, cmp_idx_next;
    result_t          res_reg, res_next;

    logic             accept;
    logic             id_ok;
    logic [AW-1:0]    slot;
    logic [CW-1:0]    cmp_id;
    result_t          res_miss;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    // id must name a session in use
    assign id_ok  = (id != '0) && (IW'(id) <= IW'(total_reg));
    assign slot   = AW'(id - 1'b1);
    assign cmp_id = cmp_idx_reg + 1'b1;

    assign res_miss = '{status: STATUS_IGNORED, found_id: '0,
                        found_count: '0, found_policy: '0};

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        key_next       = key_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        res_next       = res_reg;
        wr_en          = '0;
        wr_addr        = slot;
        rd_en          = 1'b0;
        rd_addr        = rd_idx_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next   = res_miss;
                    state_next = S_DONE;
                    case (cmd)
                        CMD_APPEND:
                        begin
                            if (total_reg < CW'(ENTRIES))
                            begin
                                wr_en           = '{src: 1'b1, cnt: 1'b1, pol: 1'b1};
                                wr_addr         = total_reg[AW-1:0];
                                total_next      = total_reg + 1'b1;
                                res_next.status = STATUS_OK;
                            end
                            else
                            begin
                                res_next.status = STATUS_FULL;
                            end
                        end
                        CMD_OVERWRITE:
                        begin
                            if (id_ok)
                            begin
                                wr_en           = '{src: 1'b1, cnt: 1'b1, pol: 1'b1};
                                res_next.status = STATUS_OK;
                            end
                        end
                        CMD_SET_COUNT:
                        begin
                            if (id_ok)
                            begin
                                wr_en.cnt       = 1'b1;
                                res_next.status = STATUS_OK;
                            end
                        end
                        CMD_SET_SOURCE:
                        begin
                            if (id_ok)
                            begin
                                wr_en.src       = 1'b1;
                                res_next.status = STATUS_OK;
                            end
                        end
                        CMD_LOOKUP:
                        begin
                            key_next       = src;
                            rd_idx_next    = '0;
                            cmp_valid_next = 1'b0;
                            if (total_reg != '0)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            res_next = res_miss;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // issue the next read while comparing the previous one
                rd_en          = (rd_idx_reg < total_reg);
                cmp_valid_next = rd_en;
                cmp_idx_next   = rd_idx_reg;
                if (rd_en)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (cmp_valid_reg)
                begin
                    if (rd_src == key_reg)
                    begin
                        res_next = '{status: STATUS_OK, found_id: ID_W'(cmp_id),
                                     found_count: rd_cnt, found_policy: rd_pol};
                        state_next = S_DONE;
                    end
                    else if (cmp_id == total_reg)
                    begin
                        res_next   = res_miss;
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        rd_idx_reg  <= rd_idx_next;
        cmp_idx_reg <= cmp_idx_next;
        res_reg     <= res_next;
    end

endmodule

[rtl/srtp_crypto_session_table.sv]
// ----------------------------------------------------------------------------
// SRTP crypto session table
// Stores up to ENTRIES sessions (source id, rollover counter, policy) and
// serves append, overwrite, field update and lookup commands.
// ----------------------------------------------------------------------------
// Each command transaction yields exactly one result transaction. Append,
// overwrite and the set commands pass from acceptance in the idle state
// through the done state back to idle before the next acceptance. A lookup
// scans the source store through its single read port, one entry per cycle
// into one comparator, and stops at the first hit, so the lowest id wins; a
// miss scans every stored session, and a lookup on an empty table misses
// without a scan. The sequencer holds each result in the done state until
// the output register can take it. Commands are not accepted while a lookup
// scans. The result sits in an output register, so a new command may be
// accepted while it waits to be taken. Stored sessions need no clearing after reset.
module srtp_crypto_session_table
    import sst_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // command channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // stream_source, rollover_count, policy_number, entry_id
    input  logic [2:0]  s_tuser,   // command
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // found_id, found_count, found_policy
    output logic [1:0]  m_tuser    // status
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [SRC_W-1:0] in_src;
    logic [CNT_W-1:0] in_cnt;
    logic [POL_W-1:0] in_pol;
    logic [ID_W-1:0]  in_id;

    wr_en_t           wr_en;
    logic [AW-1:0]    wr_addr;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [SRC_W-1:0] rd_src;
    logic [CNT_W-1:0] rd_cnt;
    logic [POL_W-1:0] rd_pol;

    logic             res_valid;
    result_t          res;
    logic             res_take;

    logic             m_tvalid_reg;
    logic [47:0]      m_tdata_reg;
    logic [1:0]       m_tuser_reg;

    // unpack the command
    assign in_src = s_tdata[31:0];
    assign in_cnt = s_tdata[63:32];
    assign in_pol = s_tdata[71:64];
    assign in_id  = s_tdata[79:72];

    sst_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .cmd       (s_tuser),
        .src       (in_src),
        .cnt       (in_cnt),
        .pol       (in_pol),
        .id        (in_id),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_src    (rd_src),
        .rd_cnt    (rd_cnt),
        .rd_pol    (rd_pol),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    // session stores, one per field so that single fields can be updated
    sst_ram #(
        .WIDTH (SRC_W),
        .DEPTH (ENTRIES)
    ) u_src_ram (
        .clk     (clk),
        .wr_en   (wr_en.src),
        .wr_addr (wr_addr),
        .wr_data (in_src),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_src)
    );

    sst_ram #(
        .WIDTH (CNT_W),
        .DEPTH (ENTRIES)
    ) u_cnt_ram (
        .clk     (clk),
        .wr_en   (wr_en.cnt),
        .wr_addr (wr_addr),
        .wr_data (in_cnt),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_cnt)
    );

    sst_ram #(
        .WIDTH (POL_W),
        .DEPTH (ENTRIES)
    ) u_pol_ram (
        .clk     (clk),
        .wr_en   (wr_en.pol),
        .wr_addr (wr_addr),
        .wr_data (in_pol),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_pol)
    );

    // load the output register once it is empty or being drained
    assign res_take = res_valid && (!m_tvalid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // hold the result payload
    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            m_tdata_reg <= {res.found_policy, res.found_count, res.found_id};
            m_tuser_reg <= res.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[bench/srtp_crypto_session_table_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SRTP crypto session table testbench
// Streams append, overwrite, field update and lookup commands into the table,
// predicts each result from a shadow copy of the sessions and checks every
// result transaction field by field. Both sides idle at random in phases, and
// a long receiver hold-off and a sender pause stress the handshakes.
// ----------------------------------------------------------------------------
module srtp_crypto_session_table_tb;
    import sst_pkg::*;

    localparam int TABLE_DEPTH   = 16;
    localparam int RANDOM_ITEMS  = 1700;
    localparam int PHASE_LEN     = 575;
    localparam int PAUSE_AT      = 400;
    localparam int HOLD_AT       = 1300;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 5000;

    // one command as the driver sees it
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [SRC_W-1:0] src;
        logic [CNT_W-1:0] cnt;
        logic [POL_W-1:0] pol;
        logic [ID_W-1:0]  id;
    } session_cmd_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;   // stream_source, rollover_count, policy_number, entry_id
    logic [2:0]  s_tuser = '0;   // command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // found_id, found_count, found_policy
    logic [1:0]  m_tuser;        // status

    session_cmd_t command_queue[$];
    session_cmd_t cmd_in_flight;
    result_t      expected_results[$];

    // shadow copy of the session table
    logic [SRC_W-1:0] shadow_source [TABLE_DEPTH];
    logic [CNT_W-1:0] shadow_counter[TABLE_DEPTH];
    logic [POL_W-1:0] shadow_policy [TABLE_DEPTH];
    int               shadow_total = 0;

    int sent_count   = 0;
    int recv_count   = 0;
    int error_count  = 0;
    int stall_cycles = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    bit pause_done   = 1'b0;

    srtp_crypto_session_table #(.ENTRIES(TABLE_DEPTH)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // add one command to the pending queue
    task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [SRC_W-1:0] src,
                             input logic [CNT_W-1:0] cnt, input logic [POL_W-1:0] pol,
                             input logic [ID_W-1:0] id);
        session_cmd_t c;
        c.cmd = cmd;
        c.src = src;
        c.cnt = cnt;
        c.pol = pol;
        c.id  = id;
        command_queue = {command_queue, c};
    endtask

    // apply one accepted command to the shadow table and queue its result
    task automatic predict_session_result(input session_cmd_t c);
        result_t r;
        int      slot;
        r = '0;
        r.status = STATUS_IGNORED;
        slot = (c.id == 0 || int'(c.id) > shadow_total) ? -1 : int'(c.id) - 1;
        case (c.cmd)
            CMD_APPEND:
            begin
                if (shadow_total < TABLE_DEPTH)
                begin
                    shadow_source[shadow_total]  = c.src;
                    shadow_counter[shadow_total] = c.cnt;
                    shadow_policy[shadow_total]  = c.pol;
                    shadow_total++;
                    r.status = STATUS_OK;
                end
                else
                begin
                    r.status = STATUS_FULL;
                end
            end
            CMD_OVERWRITE:
            begin
                if (slot >= 0)
                begin
                    shadow_source[slot]  = c.src;
                    shadow_counter[slot] = c.cnt;
                    shadow_policy[slot]  = c.pol;
                    r.status = STATUS_OK;
                end
            end
            CMD_SET_COUNT:
            begin
                if (slot >= 0)
                begin
                    shadow_counter[slot] = c.cnt;
                    r.status = STATUS_OK;
                end
            end
            CMD_SET_SOURCE:
            begin
                if (slot >= 0)
                begin
                    shadow_source[slot] = c.src;
                    r.status = STATUS_OK;
                end
            end
            CMD_LOOKUP:
            begin
                // first match wins, so stop once found
                for (int i = 0; i < shadow_total && r.status != STATUS_OK; i++)
                begin
                    if (shadow_source[i] == c.src)
                    begin
                        r.status       = STATUS_OK;
                        r.found_id     = ID_W'(i + 1);
                        r.found_count  = shadow_counter[i];
                        r.found_policy = shadow_policy[i];
                    end
                end
            end
            default:
            begin
            end
        endcase
        expected_results = {expected_results, r};
    endtask

    // command driver
    always @(posedge clk)
    begin
        bit           offer;
        session_cmd_t next_cmd;
        int           idle_pct;
        offer    = 1'b0;
        next_cmd = cmd_in_flight;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_session_result(cmd_in_flight);
                sent_count++;
            end
            idle_pct = (sent_count < PHASE_LEN) ? 28 : (sent_count < 2 * PHASE_LEN) ? 82 : 0;
            if (s_tvalid && !s_tready)
            begin
                // hold the current transaction until it is taken
                offer = 1'b1;
            end
            else if (command_queue.size() == 0)
            begin
                offer = 1'b0;
            end
            else if (!pause_done && sent_count == PAUSE_AT)
            begin
                // wait here until every outstanding result has drained
                if (expected_results.size() == 0)
                    pause_done = 1'b1;
            end
            else if ($urandom_range(0, 99) >= idle_pct)
            begin
                next_cmd = command_queue.pop_front();
                offer    = 1'b1;
            end
        end
        cmd_in_flight = next_cmd;
        s_tvalid <= offer;
        s_tdata  <= {next_cmd.id, next_cmd.pol, next_cmd.cnt, next_cmd.src};
        s_tuser  <= next_cmd.cmd;
    end

    // result monitor and receiver back-pressure
    always @(posedge clk)
    begin
        result_t exp_r;
        bit      ready;
        int      idle_pct;
        ready = 1'b0;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                recv_count++;
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with no command outstanding");
                    error_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (m_tuser !== exp_r.status)
                    begin
                        $error("status: expected %0h, got %0h", exp_r.status, m_tuser);
                        error_count++;
                    end
                    if (m_tdata[7:0] !== exp_r.found_id)
                    begin
                        $error("found_id: expected %0h, got %0h", exp_r.found_id, m_tdata[7:0]);
                        error_count++;
                    end
                    if (m_tdata[39:8] !== exp_r.found_count)
                    begin
                        $error("found_count: expected %0h, got %0h", exp_r.found_count,
                               m_tdata[39:8]);
                        error_count++;
                    end
                    if (m_tdata[47:40] !== exp_r.found_policy)
                    begin
                        $error("found_policy: expected %0h, got %0h", exp_r.found_policy,
                               m_tdata[47:40]);
                        error_count++;
                    end
                end
            end
            idle_pct = (sent_count < PHASE_LEN) ? 82 : (sent_count < 2 * PHASE_LEN) ? 28 : 0;
            if (!hold_done && recv_count == HOLD_AT)
            begin
                // start a long hold-off so the table backs up
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
                hold_left--;
            else
                ready = ($urandom_range(0, 99) >= idle_pct);
        end
        m_tready <= ready;
    end

    // count cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    // stimulus and end of run
    initial
    begin
        logic [SRC_W-1:0] source_pool[8];
        logic [SRC_W-1:0] src;
        logic [CNT_W-1:0] cnt;
        logic [ID_W-1:0]  id;
        logic [CMD_W-1:0] cmd;
        int               pick;

        // empty table: lookup misses, updates are ignored
        queue_cmd(CMD_LOOKUP,     32'h0000_0000, 32'h0000_0000, 8'h00, 8'h00);
        queue_cmd(CMD_OVERWRITE,  32'h1111_1111, 32'h2222_2222, 8'h33, 8'h01);
        queue_cmd(CMD_SET_COUNT,  32'h0000_0000, 32'h4444_4444, 8'h00, 8'h00);
        // appends with extreme field values and a duplicate source
        queue_cmd(CMD_APPEND,     32'hFFFF_FFFF, 32'h0000_0000, 8'hFF, 8'hFF);
        queue_cmd(CMD_APPEND,     32'h0000_0000, 32'hFFFF_FFFF, 8'h00, 8'h00);
        queue_cmd(CMD_APPEND,     32'h1234_5678, 32'hA5A5_A5A5, 8'h5A, 8'h80);
        queue_cmd(CMD_APPEND,     32'h0000_0000, 32'h0000_0001, 8'h01, 8'h7F);
        // lowest id wins on several matches, and a plain miss
        queue_cmd(CMD_LOOKUP,     32'h0000_0000, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
        queue_cmd(CMD_LOOKUP,     32'hFFFF_FFFF, 32'h0000_0000, 8'h00, 8'h00);
        queue_cmd(CMD_LOOKUP,     32'hDEAD_BEEF, 32'h0000_0000, 8'h00, 8'h00);
        // updates on valid ids
        queue_cmd(CMD_OVERWRITE,  32'hDEAD_BEEF, 32'h5555_5555, 8'h7F, 8'h03);
        queue_cmd(CMD_SET_COUNT,  32'h0BAD_F00D, 32'hFFFF_FFFF, 8'hAA, 8'h01);
        queue_cmd(CMD_SET_SOURCE, 32'hFFFF_FFFF, 32'h0000_0000, 8'h55, 8'h04);
        queue_cmd(CMD_LOOKUP,     32'hFFFF_FFFF, 32'h0000_0000, 8'h00, 8'h00);
        queue_cmd(CMD_LOOKUP,     32'hDEAD_BEEF, 32'h0000_0000, 8'h00, 8'h00);
        // id zero or beyond the count changes nothing
        queue_cmd(CMD_SET_COUNT,  32'h0000_0000, 32'h9999_9999, 8'h00, 8'h05);
        queue_cmd(CMD_SET_SOURCE, 32'h0000_0000, 32'h0000_0000, 8'h00, 8'h00);
        queue_cmd(CMD_OVERWRITE,  32'hCAFE_CAFE, 32'h0000_0000, 8'h11, 8'hFF);
        queue_cmd(CMD_LOOKUP,     32'hCAFE_CAFE, 32'h0000_0000, 8'h00, 8'h00);
        // unknown commands are ignored
        queue_cmd(3'd5,           32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'h01);
        queue_cmd(3'd6,           32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'h02);
        queue_cmd(3'd7,           32'h0000_0000, 32'h0000_0000, 8'h00, 8'h00);
        queue_cmd(CMD_LOOKUP,     32'h0000_0000, 32'h0000_0000, 8'h00, 8'h00);

        // a small pool of sources keeps lookups hitting and matches repeating
        source_pool[0] = 32'h0000_0000;
        source_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 8; i++)
            source_pool[i] = $urandom;

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
                cmd = CMD_APPEND;
            else if (pick < 32)
                cmd = CMD_OVERWRITE;
            else if (pick < 44)
                cmd = CMD_SET_COUNT;
            else if (pick < 58)
                cmd = CMD_SET_SOURCE;
            else
                cmd = CMD_LOOKUP;

            src = ($urandom_range(0, 99) < 70) ? source_pool[$urandom_range(0, 7)] : $urandom;

            pick = $urandom_range(0, 9);
            cnt = (pick == 0) ? 32'h0000_0000 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;

            pick = $urandom_range(0, 99);
            if (pick < 60)
                id = ID_W'($urandom_range(1, TABLE_DEPTH));
            else if (pick < 75)
                id = '0;
            else if (pick < 90)
                id = ID_W'($urandom_range(TABLE_DEPTH + 1, 255));
            else
                id = ID_W'($urandom_range(0, 255));

            queue_cmd(cmd, src, cnt, POL_W'($urandom_range(0, 255)), id);
        end

        // release reset
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // drain every command and result, then let the block settle
        while (command_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (TABLE_DEPTH + 8) @(posedge clk);

        if (error_count == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/sst_pkg.sv
rtl/sst_ram.sv
rtl/sst_ctrl.sv
rtl/srtp_crypto_session_table.sv
bench/srtp_crypto_session_table_tb.sv
